// ===== hw/rtl/mfa_pkg.sv =====
// Shared types and constants for the minifloat adder.
package mfa_pkg;
  localparam int WORD_WIDTH = 8;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ALIGN = 3'b010,
    ST_NORM  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic align;
    logic norm;
  } ctrl_t;

  typedef struct packed {
    logic norm_done;
  } stat_t;
endpackage

// ===== hw/rtl/minifloat_adder_core.sv =====
// Top level of the minifloat adder: controller plus datapath.
//
// Usage: drive operand_a and operand_b and raise start while busy is low;
// that edge accepts the transaction. busy stays high until the result is out.
// The result appears on sum_bits/overflowed for exactly one cycle with
// result_valid high; the receiver cannot stall, so take it then.
// Sequence: the accept edge registers the operands, the align state aligns
// and adds, then the normalize state shifts left one bit per cycle (0 to
// MAN_WIDTH shifts) and strobes the result in its last cycle. busy drops
// the cycle after the strobe, so a new transaction can only be accepted
// once the current one is through. The rate is set by the one-bit-per-cycle
// left normalization loop in the datapath.
// Operands use 1 sign, EXP_WIDTH exponent and MAN_WIDTH mantissa bits,
// bias 2^(EXP_WIDTH-1)-1, with subnormals; an exponent reaching all ones
// saturates (mantissa 0) and raises overflowed. Truncation throughout.
// Reset (rst, synchronous) returns the controller to idle and drops any
// transaction in flight; no result is strobed for it.
module minifloat_adder_core #(
  parameter int EXP_WIDTH = 4,
  parameter int MAN_WIDTH = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  output logic       result_valid,
  output logic [7:0] sum_bits,
  output logic       overflowed
);
  import mfa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequence the transaction
  mfa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy),
    .done (result_valid)
  );

  // compute the sum
  mfa_datapath #(
    .EXP_WIDTH(EXP_WIDTH),
    .MAN_WIDTH(MAN_WIDTH)
  ) u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .stat      (stat),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .sum_bits  (sum_bits),
    .overflowed(overflowed)
  );

  // a result is only strobed while a transaction is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result strobe while idle");

  // an accepted transaction never strobes in the next cycle (align first)
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid) else $error("result too early");

  // a strobe frees the block on the next cycle
  a_free: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !busy) else $error("busy after result");

  // overflow only comes with a saturated exponent and zero mantissa
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflowed) |-> (sum_bits[MAN_WIDTH-1:0] == '0))
    else $error("overflow with nonzero mantissa");
endmodule

// ===== hw/rtl/mfa_datapath.sv =====
// Datapath: operand split, alignment, magnitude add, normalize, pack.
module mfa_datapath #(
  parameter int EXP_WIDTH = 4,
  parameter int MAN_WIDTH = 3
) (
  input  logic                 clk,
  input  mfa_pkg::ctrl_t       ctrl,
  output mfa_pkg::stat_t       stat,
  input  logic [7:0]           operand_a,
  input  logic [7:0]           operand_b,
  output logic [7:0]           sum_bits,
  output logic                 overflowed
);
  import mfa_pkg::*;

  localparam int SW = MAN_WIDTH + 2;   // significand incl. carry
  localparam int XW = EXP_WIDTH + 1;   // exponent with headroom
  localparam int FW = 1 + EXP_WIDTH + MAN_WIDTH;
  localparam logic [XW-1:0] EXP_ONES = XW'((1 << EXP_WIDTH) - 1);

  logic [FW-1:0] fa, fb;
  logic          sa, sb;
  logic [EXP_WIDTH-1:0] ea, eb;
  logic [SW-1:0] ma, mb;

  // operand registers
  logic          ra_s, rb_s;
  logic [XW-1:0] ra_e, rb_e;
  logic [SW-1:0] ra_m, rb_m;

  // working registers
  logic          sgn;
  logic [XW-1:0] ex;
  logic [SW-1:0] mag;
  logic          ovf;

  assign fa = FW'(operand_a);
  assign fb = FW'(operand_b);
  assign sa = fa[FW-1];
  assign sb = fb[FW-1];
  assign ea = fa[FW-2:MAN_WIDTH];
  assign eb = fb[FW-2:MAN_WIDTH];
  assign ma = (ea == '0) ? SW'({fa[MAN_WIDTH-1:0], 1'b0}) : SW'({1'b1, fa[MAN_WIDTH-1:0]});
  assign mb = (eb == '0) ? SW'({fb[MAN_WIDTH-1:0], 1'b0}) : SW'({1'b1, fb[MAN_WIDTH-1:0]});

  logic [XW-1:0] diff;
  logic [SW-1:0] sha, shb, mag_sum;
  logic [XW-1:0] ex_al;
  logic          sgn_al;
  logic [SW-1:0] mag_c;
  logic [XW-1:0] ex_c;

  always_comb begin
    if (ra_e > rb_e) begin
      diff  = ra_e - rb_e;
      sha   = ra_m;
      shb   = (diff >= XW'(SW)) ? '0 : (rb_m >> diff);
      ex_al = ra_e;
    end else begin
      diff  = rb_e - ra_e;
      shb   = rb_m;
      sha   = (diff >= XW'(SW)) ? '0 : (ra_m >> diff);
      ex_al = rb_e;
    end
    if (ra_s == rb_s) begin
      mag_sum = sha + shb;
      sgn_al  = ra_s;
    end else if (sha >= shb) begin
      mag_sum = sha - shb;
      sgn_al  = ra_s;
    end else begin
      mag_sum = shb - sha;
      sgn_al  = rb_s;
    end
    if (mag_sum[SW-1]) begin
      mag_c = mag_sum >> 1;
      ex_c  = ex_al + XW'(1);
    end else begin
      mag_c = mag_sum;
      ex_c  = ex_al;
    end
  end

  assign stat.norm_done = mag[MAN_WIDTH] || (ex == '0) || (mag == '0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ra_s <= sa;
      rb_s <= sb;
      ra_e <= XW'(ea);
      rb_e <= XW'(eb);
      ra_m <= ma;
      rb_m <= mb;
    end
    if (ctrl.align) begin
      sgn <= sgn_al;
      ovf <= 1'b0;
      if (mag_c == '0) begin
        ex  <= '0;
        mag <= '0;
      end else if (ex_c >= EXP_ONES) begin
        ex  <= EXP_ONES;
        mag <= '0;
        ovf <= 1'b1;
      end else begin
        ex  <= ex_c;
        mag <= mag_c;
      end
    end else if (ctrl.norm && !stat.norm_done) begin
      mag <= mag << 1;
      ex  <= ex - XW'(1);
    end
  end

  logic [MAN_WIDTH-1:0] man;
  logic [FW-1:0]        word;
  assign man  = (ex != '0) ? mag[MAN_WIDTH-1:0] : mag[MAN_WIDTH:1];
  assign word = {sgn, ex[EXP_WIDTH-1:0], man};
  assign sum_bits   = 8'(word);
  assign overflowed = ovf;
endmodule

// ===== hw/rtl/mfa_ctrl.sv =====
// Controller: sequences load, align/add and iterative normalize.
module mfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mfa_pkg::stat_t stat,
  output mfa_pkg::ctrl_t ctrl,
  output logic           busy,
  output logic           done
);
  import mfa_pkg::*;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctrl = '0;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        ctrl.load = start;
        if (start) state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        ctrl.align = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        ctrl.norm = 1'b1;
        if (stat.norm_done) begin
          done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end
endmodule

// ===== sim/minifloat_adder_core_test.sv =====
// Self-checking testbench for the minifloat adder core: directed and random operand pairs.
module minifloat_adder_core_test;
  localparam int EW = 4;
  localparam int MW = 3;
  localparam int EXP_ONES = (1 << EW) - 1;
  localparam int MAN_ONES = (1 << MW) - 1;
  localparam int HIDDEN = 1 << MW;
  localparam int CARRY = 1 << (MW + 1);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
  } operands_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       ovf;
  } sum_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] operand_a;
  logic [7:0] operand_b;
  logic       result_valid;
  logic [7:0] sum_bits;
  logic       overflowed;

  operands_t pending_ops[$];
  sum_t      expected_sums[$];
  int        idle_pct;
  int        error_count;
  int        sums_checked;
  int        overflows_seen;
  int        quiet_cycles;
  bit        stimulus_done;

  minifloat_adder_core #(.EXP_WIDTH(EW), .MAN_WIDTH(MW)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand_a(operand_a), .operand_b(operand_b),
    .result_valid(result_valid), .sum_bits(sum_bits), .overflowed(overflowed)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predict the packed sum: expand hidden bit, align with truncation, add or
  // subtract magnitudes, then normalize with saturation at all-ones exponent.
  function automatic sum_t add_minifloats(logic [7:0] a, logic [7:0] b);
    int unsigned sa, ea, ma, sb, eb, mb, ex, mag, sgn, man, ovf, sh;
    sum_t r;
    sa = a[7];
    ea = (a >> MW) & EXP_ONES;
    ma = (ea == 0) ? ((a & MAN_ONES) << 1) : (HIDDEN | (a & MAN_ONES));
    sb = b[7];
    eb = (b >> MW) & EXP_ONES;
    mb = (eb == 0) ? ((b & MAN_ONES) << 1) : (HIDDEN | (b & MAN_ONES));
    ovf = 0;
    if (ea > eb) begin
      sh = ea - eb;
      mb = (sh >= 32) ? 0 : (mb >> sh);
      ex = ea;
    end else begin
      sh = eb - ea;
      ma = (sh >= 32) ? 0 : (ma >> sh);
      ex = eb;
    end
    if (sa == sb) begin
      mag = ma + mb;
      sgn = sa;
    end else if (ma >= mb) begin
      mag = ma - mb;
      sgn = sa;
    end else begin
      mag = mb - ma;
      sgn = sb;
    end
    if (mag & CARRY) begin
      mag = mag >> 1;
      ex = ex + 1;
    end
    if (mag == 0) begin
      ex = 0;
    end else if (ex >= EXP_ONES) begin
      ex = EXP_ONES;
      mag = 0;
      ovf = 1;
    end else begin
      // Shift left until the hidden bit is set, stopping at exponent 0.
      for (int g = 0; g <= MW + 1; g++) begin
        if ((mag & HIDDEN) || ex == 0) break;
        mag = mag << 1;
        ex = ex - 1;
      end
    end
    man = (ex > 0) ? (mag & MAN_ONES) : ((mag >> 1) & MAN_ONES);
    r.sum = 8'((sgn << (EW + MW)) | ((ex & EXP_ONES) << MW) | man);
    r.ovf = ovf[0];
    return r;
  endfunction

  function automatic logic [7:0] pack_mf(int s, int e, int m);
    return 8'((s << 7) | (e << MW) | m);
  endfunction

  // Track whether the transaction on the pins was accepted at the last edge.
  logic busy_at_edge;
  always @(posedge clk) begin
    busy_at_edge <= busy | ~start;
  end

  // Driver: present the next transaction at the falling edge, drop start
  // once an accept edge has taken it. A random gap holds start low.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // previous transaction was taken at the last rising edge
      if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
        operand_a <= pending_ops[0].a;
        operand_b <= pending_ops[0].b;
        start <= 1'b1;
        void'(pending_ops.pop_front());
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
      operand_a <= pending_ops[0].a;
      operand_b <= pending_ops[0].b;
      start <= 1'b1;
      void'(pending_ops.pop_front());
    end
  end

  // Monitor: predict at accept, check strobed results, and run the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) begin
        expected_sums.push_back(add_minifloats(operand_a, operand_b));
      end
      if (result_valid) begin
        if (expected_sums.size() == 0) begin
          $error("sum_bits: unexpected result 0x%02h", sum_bits);
          error_count++;
        end else begin
          if (sum_bits !== expected_sums[0].sum) begin
            $error("sum_bits: expected 0x%02h actual 0x%02h", expected_sums[0].sum, sum_bits);
            error_count++;
          end
          if (overflowed !== expected_sums[0].ovf) begin
            $error("overflowed: expected %0b actual %0b", expected_sums[0].ovf, overflowed);
            error_count++;
          end
          if (expected_sums[0].ovf) overflows_seen <= overflows_seen + 1;
          void'(expected_sums.pop_front());
          sums_checked <= sums_checked + 1;
        end
      end
      if ((start && !busy) || result_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !stimulus_done) begin
        $display("Watchdog expired: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int s, e, m;
    rst = 1'b1;
    start = 1'b0;
    operand_a = 8'h00;
    operand_b = 8'h00;
    idle_pct = 0;
    error_count = 0;
    sums_checked = 0;
    overflows_seen = 0;
    quiet_cycles = 0;
    stimulus_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zeros, extremes, cancellation, carry, subnormals, saturation.
    pending_ops.push_back('{8'h00, 8'h00});
    pending_ops.push_back('{8'h80, 8'h00});
    pending_ops.push_back('{8'hFF, 8'hFF});
    pending_ops.push_back('{8'h7F, 8'h7F});
    pending_ops.push_back('{8'h7F, 8'hFF});
    pending_ops.push_back('{8'hFF, 8'h7F});
    pending_ops.push_back('{8'h38, 8'hB8});
    pending_ops.push_back('{8'hB8, 8'h38});
    pending_ops.push_back('{8'h3F, 8'h3F});
    pending_ops.push_back('{8'h70, 8'h70});
    pending_ops.push_back('{8'h68, 8'h68});
    pending_ops.push_back('{8'h01, 8'h01});
    pending_ops.push_back('{8'h07, 8'h07});
    pending_ops.push_back('{8'h07, 8'h01});
    pending_ops.push_back('{8'h08, 8'h81});
    pending_ops.push_back('{8'h08, 8'h87});
    pending_ops.push_back('{8'h40, 8'hBF});
    pending_ops.push_back('{8'h39, 8'hB8});
    pending_ops.push_back('{8'h78, 8'h01});
    pending_ops.push_back('{8'h01, 8'h78});
    pending_ops.push_back('{8'h55, 8'hAA});
    pending_ops.push_back('{8'hAA, 8'h55});

    // Random phases with different sender idling.
    for (int ph = 0; ph < 4; ph++) begin
      while (pending_ops.size() > 0 || expected_sums.size() > 0 || start)
        @(posedge clk);
      idle_pct = (ph == 1) ? 63 : (ph == 2) ? 20 : 0;
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        case ($urandom_range(3))
          0: pending_ops.push_back('{8'($urandom), 8'($urandom)});
          1: begin
            // near cancellation: close exponents, opposite signs
            s = $urandom_range(1);
            e = $urandom_range(EXP_ONES);
            m = $urandom_range(MAN_ONES);
            pending_ops.push_back('{pack_mf(s, e, m),
              pack_mf(1 - s, (e > 0 && $urandom_range(1)) ? e - 1 : e, $urandom_range(MAN_ONES))});
          end
          2: begin
            // large exponents, likely saturation
            s = $urandom_range(1);
            pending_ops.push_back('{pack_mf(s, $urandom_range(EXP_ONES, EXP_ONES - 2),
              $urandom_range(MAN_ONES)), pack_mf(s, $urandom_range(EXP_ONES, EXP_ONES - 2),
              $urandom_range(MAN_ONES))});
          end
          default:
            // small and subnormal values
            pending_ops.push_back('{pack_mf($urandom_range(1), $urandom_range(2),
              $urandom_range(MAN_ONES)), pack_mf($urandom_range(1), $urandom_range(2),
              $urandom_range(MAN_ONES))});
        endcase
      end
    end
    while (pending_ops.size() > 0 || expected_sums.size() > 0 || start)
      @(posedge clk);
    stimulus_done = 1'b1;
    repeat (MW + 8) @(posedge clk);

    $display("Checked %0d sums (%0d saturated) over four sender idling phases.",
      sums_checked, overflows_seen);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
